// ===== design/lcdm_pkg.sv =====
`timescale 1ns / 1ps

package lcdm_pkg;

  localparam int MAX_COLS = 20;
  localparam int TEXT_CAP = 64;
  localparam int GAP_COLS = 3;

  // Field widths fixed by the interface.
  localparam int CHAR_W = 8;
  localparam int COL_W  = 5;
  localparam int TIME_W = 32;
  localparam int IVL_W  = 16;

  localparam int ADDR_W = $clog2(TEXT_CAP);
  localparam int LEN_W  = $clog2(TEXT_CAP);
  localparam int SPAN_W = $clog2(TEXT_CAP + GAP_COLS);
  // Scroll offset and text index share one width wide enough for both uses.
  localparam int IDX_W  = (SPAN_W > COL_W) ? SPAN_W : COL_W;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = CHAR_W'(32);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_IVL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IVL     = 2'd2;

  // Input kind codes.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_RENDER = 1'b1;

endpackage

// ===== design/lcdm_ram.sv =====
`timescale 1ns / 1ps

module lcdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lcdm_step.sv =====
`timescale 1ns / 1ps

// Shared increment-and-wrap unit: advances the scroll offset once per step
// and the text index once per emitted column.
module lcdm_step (
  input  logic [lcdm_pkg::IDX_W-1:0] val,
  input  logic [lcdm_pkg::IDX_W-1:0] modulus,
  input  logic                       wrap_en,
  output logic [lcdm_pkg::IDX_W-1:0] next,
  output logic                       wrapped
);
  import lcdm_pkg::*;

  logic [IDX_W-1:0] inc;

  always_comb begin
    inc     = val + IDX_W'(1);
    wrapped = wrap_en && (inc == modulus);
    next    = wrapped ? '0 : inc;
  end

endmodule

// ===== design/lcd_text_marquee_scroller.sv =====
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// in        in_valid / in_stall   in_kind, in_char_code, in_now_ms
// out       out_valid / out_stall out_glyph, out_column, out_last_column
// cfg       cfg_we (no wait)      cfg_index, cfg_data
//
// Load beat: the accept cycle reads the store at the load pointer and the next
// compares and writes it. Render beat: the accept cycle, the timer state, then
// the emit state, which walks the visible columns in turn on the store's single
// read port; output stalls stretch it. The input stalls for the whole beat, but
// the last column may still wait while the next beat is taken.
// rst_n is synchronous; the text store itself is not cleared.
module lcd_text_marquee_scroller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic [lcdm_pkg::CHAR_W-1:0]         in_char_code,
  input  logic [lcdm_pkg::TIME_W-1:0]         in_now_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lcdm_pkg::CHAR_W-1:0]         out_glyph,
  output logic [lcdm_pkg::COL_W-1:0]          out_column,
  output logic                                out_last_column,
  input  logic                                cfg_we,
  input  logic [lcdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcdm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lcdm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_TIME = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;

  // Configuration.
  logic [COL_W-1:0]  width_r, width_nxt;
  logic [IVL_W-1:0]  hold_ivl_r, hold_ivl_nxt;
  logic [IVL_W-1:0]  step_ivl_r, step_ivl_nxt;

  // Text and scroll state.
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  lp_r, lp_nxt;
  logic              differs_r, differs_nxt;
  logic [IDX_W-1:0]  offset_r, offset_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic              running_r, running_nxt;
  logic              hold_r, hold_nxt;

  // Render walk.
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              short_r, short_nxt;

  // Result register.
  logic              ov_r, ov_nxt;
  logic [CHAR_W-1:0] glyph_r, glyph_nxt;
  logic [COL_W-1:0]  column_r, column_nxt;
  logic              lastc_r, lastc_nxt;

  logic [CHAR_W-1:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic              ram_we;

  logic [COL_W-1:0]  eff_w;
  logic [IDX_W-1:0]  cycle_len;
  logic [IDX_W-1:0]  step_val;
  logic [IDX_W-1:0]  step_next;
  logic              step_wrapped;
  logic              step_wrap_en;
  logic [TIME_W-1:0] elapsed;
  logic [IVL_W-1:0]  interval;
  logic              due;
  logic              out_free;
  logic              in_acc;
  logic [LEN_W-1:0]  lp_inc;
  logic              lp_room;

  lcdm_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (TEXT_CAP)
  ) u_text (
    .clk   (clk),
    .we    (ram_we),
    .waddr (lp_r[ADDR_W-1:0]),
    .wdata (ch_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  lcdm_step u_step (
    .val     (step_val),
    .modulus (cycle_len),
    .wrap_en (step_wrap_en),
    .next    (step_next),
    .wrapped (step_wrapped)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign in_acc          = in_valid && !in_stall;
  assign out_valid       = ov_r;
  assign out_glyph       = glyph_r;
  assign out_column      = column_r;
  assign out_last_column = lastc_r;
  assign out_free        = !ov_r || !out_stall;

  // A zero width or any width beyond the display selects the full display.
  assign eff_w     = (width_r == '0 || width_r > COL_W'(MAX_COLS)) ? COL_W'(MAX_COLS) : width_r;
  assign cycle_len = IDX_W'(len_r) + IDX_W'(GAP_COLS);

  // The step unit advances the offset in the timer cycle, the index otherwise.
  assign step_val     = (state_r == S_TIME) ? offset_r : idx_r;
  assign step_wrap_en = (state_r == S_TIME) ? 1'b1 : !short_r;

  // Elapsed time is modulo 2^32; a stopped timer starts at the current time.
  assign elapsed  = running_r ? (now_r - last_r) : '0;
  assign interval = hold_r ? hold_ivl_r : step_ivl_r;
  assign due      = elapsed >= TIME_W'(interval);

  assign ram_we  = (state_r == S_LOAD) && (ch_r != '0) && lp_room;
  assign lp_room = lp_r < LEN_W'(TEXT_CAP - 1);
  assign lp_inc  = lp_r + LEN_W'(1);

  // During a render the read address follows the next index (idx_nxt), so
  // the registered read data always matches the column being emitted.
  assign raddr = (state_r == S_TIME || state_r == S_EMIT) ? idx_nxt[ADDR_W-1:0]
                                                          : lp_r[ADDR_W-1:0];

  always_comb begin
    logic             end_txt;
    logic [LEN_W-1:0] lp_new;
    logic             diff_new;

    state_nxt    = state_r;
    ch_nxt       = ch_r;
    now_nxt      = now_r;
    width_nxt    = width_r;
    hold_ivl_nxt = hold_ivl_r;
    step_ivl_nxt = step_ivl_r;
    len_nxt      = len_r;
    lp_nxt       = lp_r;
    differs_nxt  = differs_r;
    offset_nxt   = offset_r;
    last_nxt     = last_r;
    running_nxt  = running_r;
    hold_nxt     = hold_r;
    idx_nxt      = idx_r;
    col_nxt      = col_r;
    short_nxt    = short_r;
    ov_nxt       = ov_r && out_stall;
    glyph_nxt    = glyph_r;
    column_nxt   = column_r;
    lastc_nxt    = lastc_r;
    end_txt      = 1'b0;
    lp_new       = lp_r;
    diff_new     = differs_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ch_nxt    = in_char_code;
          now_nxt   = in_now_ms;
          state_nxt = (in_kind == KIND_RENDER) ? S_TIME : S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = S_IDLE;
        if (ch_r == '0) begin
          end_txt = 1'b1;
        end else begin
          if (lp_room) begin
            if (lp_r >= len_r || rdata != ch_r) begin
              diff_new = 1'b1;
            end
            lp_new = lp_inc;
          end
          if (lp_new >= LEN_W'(TEXT_CAP - 1)) begin
            end_txt = 1'b1;
          end
        end
        lp_nxt      = lp_new;
        differs_nxt = diff_new;
        if (end_txt) begin
          if (diff_new || lp_new != len_r) begin
            len_nxt     = lp_new;
            offset_nxt  = '0;
            last_nxt    = '0;
            running_nxt = 1'b0;
            hold_nxt    = 1'b1;
          end
          lp_nxt      = '0;
          differs_nxt = 1'b0;
        end
      end
      S_TIME: begin
        state_nxt = S_EMIT;
        col_nxt   = '0;
        if (IDX_W'(len_r) <= IDX_W'(eff_w)) begin
          // Short text stands still and is padded with blanks.
          short_nxt  = 1'b1;
          offset_nxt = '0;
          idx_nxt    = '0;
        end else begin
          short_nxt   = 1'b0;
          running_nxt = 1'b1;
          if (!running_r) begin
            last_nxt = now_r;
          end
          if (due) begin
            last_nxt   = now_r;
            offset_nxt = step_next;
            hold_nxt   = step_wrapped;
          end
          idx_nxt = due ? step_next : offset_r;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          glyph_nxt  = (idx_r < IDX_W'(len_r)) ? rdata : BLANK_CHAR;
          column_nxt = col_r;
          lastc_nxt  = (col_r == eff_w - COL_W'(1));
          idx_nxt    = step_next;
          col_nxt    = col_r + COL_W'(1);
          if (col_r == eff_w - COL_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_WIDTH: begin
          width_nxt   = cfg_data[COL_W-1:0];
          offset_nxt  = '0;
          last_nxt    = '0;
          running_nxt = 1'b0;
          hold_nxt    = 1'b1;
        end
        REG_HOLD_IVL: hold_ivl_nxt = cfg_data[IVL_W-1:0];
        REG_STEP_IVL: step_ivl_nxt = cfg_data[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      width_r    <= COL_W'(MAX_COLS);
      hold_ivl_r <= IVL_W'(1500);
      step_ivl_r <= IVL_W'(400);
      len_r      <= '0;
      lp_r       <= '0;
      differs_r  <= 1'b0;
      offset_r   <= '0;
      last_r     <= '0;
      running_r  <= 1'b0;
      hold_r     <= 1'b1;
      ov_r       <= 1'b0;
      idx_r      <= '0;
      col_r      <= '0;
      short_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      width_r    <= width_nxt;
      hold_ivl_r <= hold_ivl_nxt;
      step_ivl_r <= step_ivl_nxt;
      len_r      <= len_nxt;
      lp_r       <= lp_nxt;
      differs_r  <= differs_nxt;
      offset_r   <= offset_nxt;
      last_r     <= last_nxt;
      running_r  <= running_nxt;
      hold_r     <= hold_nxt;
      ov_r       <= ov_nxt;
      idx_r      <= idx_nxt;
      col_r      <= col_nxt;
      short_r    <= short_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r     <= ch_nxt;
    now_r    <= now_nxt;
    glyph_r  <= glyph_nxt;
    column_r <= column_nxt;
    lastc_r  <= lastc_nxt;
  end

endmodule
